>>> rtl/pebt_pkg.sv
`timescale 1ns / 1ps

package pebt_pkg;

  // Block grouping of converter samples
  localparam int BLOCK_SAMPLES = 50;
  localparam int MAX_BLOCKS    = 255;
  localparam int SAMPLE_CNT_W  = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int BLOCK_CNT_W   = $clog2(MAX_BLOCKS + 1);

  // Field and state widths
  localparam int CODE_W      = 16;
  localparam int BLOCK_SUM_W = 22;
  localparam int TOTAL_W     = 30;
  localparam int CUR_W       = 15;
  localparam int VOLT_W      = 18;
  localparam int PWR_W       = 22;
  localparam int BUF_W       = 30;
  localparam int LIMIT_W     = 20;
  localparam int TICK_W      = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 88;

  // Intermediate widths
  localparam int DIFF_W  = TOTAL_W + 1;
  localparam int MAG_W   = TOTAL_W;
  localparam int HEAD_W  = 24;
  localparam int DELTA_W = 34;

  // Shared bit-serial divider
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 27;
  localparam int DIV_CNT_W = 6;
  localparam int VOLT_STEPS = 28;
  localparam int CUR_STEPS  = 41;
  localparam int PWR_STEPS  = 31;

  // Scaling constants
  localparam int VOLT_MUL   = 4000;
  localparam int VOLT_DEN   = 1429;
  localparam int CUR_OFS_K  = 25 * BLOCK_SAMPLES;
  localparam int CUR_DEN_K  = 7771 * BLOCK_SAMPLES;
  localparam int CUR_SCALE  = 2000;
  localparam int PWR_DEN    = 1000;
  localparam int CUR_LIMIT  = 8500;
  localparam int PWR_LIMIT  = 1560000;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS     = 2'd2;
  localparam logic [LIMIT_W-1:0] RST_POWER_LIMIT = 20'd20000;
  localparam logic [BUF_W-1:0]   RST_BUFFER_MAX  = 30'd200000000;
  localparam logic [TICK_W-1:0]  RST_TICK_MS     = 10'd5;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_VDIV   = 9'b000000010,
    ST_CPREP  = 9'b000000100,
    ST_CLOAD  = 9'b000001000,
    ST_CDIV   = 9'b000010000,
    ST_PMUL   = 9'b000100000,
    ST_PDIV   = 9'b001000000,
    ST_ENERGY = 9'b010000000,
    ST_EOUT   = 9'b100000000
  } state_t;

endpackage

>>> rtl/power_energy_buffer_tracker.sv
`timescale 1ns / 1ps
// A sample is accepted in ST_IDLE and gives no result. A tick divides for voltage, current
// (skipped with no finished block) and power on one shared restoring divider at one quotient
// bit a cycle (28, 41 and 31 steps), then updates the energy in ST_ENERGY and ST_EOUT. One
// sample a cycle while idle, also with a result waiting; a tick holds off input and stalls
// in ST_EOUT while a result waits. Reset (rst_n low, synchronous) restores the register
// defaults and clears the accumulators, energy buffer, last current and out valid.

module power_energy_buffer_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pebt_pkg::IN_DATA_W-1:0]      in_tdata,  // current_code[15:0], voltage_code[31:16]
  input  logic                                in_tuser,  // command
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pebt_pkg::OUT_DATA_W-1:0]     out_tdata, // current_ma[14:0], voltage_mv[32:15],
                                                         // power_mw[54:33], buffer_uj[84:55]
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pebt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pebt_pkg::BUF_W-1:0]          cfg_data
);

  // Control state
  pebt_pkg::state_t                          state_r, state_nxt;
  logic [pebt_pkg::LIMIT_W-1:0]              lim_r, lim_nxt;
  logic [pebt_pkg::BUF_W-1:0]                bmax_r, bmax_nxt;
  logic [pebt_pkg::TICK_W-1:0]               tick_r, tick_nxt;
  logic signed [pebt_pkg::BLOCK_SUM_W-1:0]   bsum_r, bsum_nxt;
  logic [pebt_pkg::SAMPLE_CNT_W-1:0]         scnt_r, scnt_nxt;
  logic signed [pebt_pkg::TOTAL_W-1:0]       total_r, total_nxt;
  logic [pebt_pkg::BLOCK_CNT_W-1:0]          nblk_r, nblk_nxt;
  logic signed [pebt_pkg::CUR_W-1:0]         last_cur_r, last_cur_nxt;
  logic [pebt_pkg::BUF_W-1:0]                energy_r, energy_nxt;
  logic                                      out_valid_r, out_valid_nxt;
  logic [pebt_pkg::DIV_CNT_W-1:0]            cnt_r, cnt_nxt;

  // Payload state
  logic [pebt_pkg::VOLT_W-1:0]               volt_r, volt_nxt;
  logic signed [pebt_pkg::CUR_W-1:0]         cur_r, cur_nxt;
  logic signed [pebt_pkg::PWR_W-1:0]         pw_r, pw_nxt;
  logic                                      neg_r, neg_nxt;
  logic [pebt_pkg::MAG_W-1:0]                mag_r, mag_nxt;
  logic [pebt_pkg::DIV_DEN_W-1:0]            den_r, den_nxt;
  logic [pebt_pkg::DIV_DEN_W-1:0]            rem_r, rem_nxt;
  logic [pebt_pkg::DIV_NUM_W-1:0]            quo_r, quo_nxt;
  logic signed [pebt_pkg::DELTA_W-1:0]       delta_r, delta_nxt;
  logic [pebt_pkg::OUT_DATA_W-1:0]           out_data_r, out_data_nxt;

  // Datapath intermediates
  logic                                      in_xfer;
  logic signed [pebt_pkg::CODE_W-1:0]        code;
  logic signed [pebt_pkg::BLOCK_SUM_W-1:0]   sum_add;
  logic signed [pebt_pkg::TOTAL_W-1:0]       total_add;
  logic [pebt_pkg::VOLT_STEPS-1:0]           vnum;
  logic signed [pebt_pkg::DIFF_W-1:0]        diff;
  logic signed [pebt_pkg::DIFF_W-1:0]        diff_abs;
  logic [pebt_pkg::DIV_NUM_W-1:0]            cnum;
  logic signed [pebt_pkg::CUR_W-1:0]         cur_abs;
  logic [pebt_pkg::PWR_STEPS-1:0]            pnum;
  logic [pebt_pkg::CUR_W-1:0]                qcur;
  logic [pebt_pkg::PWR_W-1:0]                qpwr;
  logic signed [pebt_pkg::HEAD_W-1:0]        head;
  logic signed [pebt_pkg::DELTA_W-1:0]       esum;
  logic [pebt_pkg::BUF_W-1:0]                energy_new;
  logic [pebt_pkg::DIV_DEN_W:0]              rem_sh;
  logic [pebt_pkg::DIV_DEN_W:0]              rem_sub;
  logic                                      div_ge;
  logic                                      div_busy;

  assign in_tready  = (state_r == pebt_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sample accumulation
  assign code      = $signed(in_tdata[pebt_pkg::CODE_W-1:0]);
  assign sum_add   = bsum_r + pebt_pkg::BLOCK_SUM_W'(code);
  assign total_add = total_r + pebt_pkg::TOTAL_W'(sum_add);

  // Voltage numerator with the rounding half of the divisor added
  assign vnum = pebt_pkg::VOLT_STEPS'(in_tdata[2*pebt_pkg::CODE_W-1:pebt_pkg::CODE_W])
              * pebt_pkg::VOLT_STEPS'(pebt_pkg::VOLT_MUL)
              + pebt_pkg::VOLT_STEPS'(pebt_pkg::VOLT_DEN / 2);

  // Current numerator: offset of the blocks less the total, as a magnitude
  assign diff = $signed(pebt_pkg::DIFF_W'(nblk_r) * pebt_pkg::DIFF_W'(pebt_pkg::CUR_OFS_K))
              - pebt_pkg::DIFF_W'(total_r);
  assign diff_abs = diff[pebt_pkg::DIFF_W-1] ? -diff : diff;
  assign cnum = pebt_pkg::DIV_NUM_W'(mag_r) * pebt_pkg::DIV_NUM_W'(pebt_pkg::CUR_SCALE)
              + pebt_pkg::DIV_NUM_W'(den_r >> 1);

  // Power numerator from the magnitude of the current
  assign cur_abs = cur_r[pebt_pkg::CUR_W-1] ? -cur_r : cur_r;
  assign pnum = pebt_pkg::PWR_STEPS'(volt_r) * pebt_pkg::PWR_STEPS'(cur_abs)
              + pebt_pkg::PWR_STEPS'(pebt_pkg::PWR_DEN / 2);

  // Clamped quotient magnitudes
  assign qcur = (quo_r > pebt_pkg::DIV_NUM_W'(pebt_pkg::CUR_LIMIT))
              ? pebt_pkg::CUR_W'(pebt_pkg::CUR_LIMIT) : quo_r[pebt_pkg::CUR_W-1:0];
  assign qpwr = (quo_r > pebt_pkg::DIV_NUM_W'(pebt_pkg::PWR_LIMIT))
              ? pebt_pkg::PWR_W'(pebt_pkg::PWR_LIMIT) : quo_r[pebt_pkg::PWR_W-1:0];

  // Energy update, clamped to the buffer range
  assign head = $signed(pebt_pkg::HEAD_W'(lim_r)) - pebt_pkg::HEAD_W'(pw_r);
  assign esum = $signed(pebt_pkg::DELTA_W'(energy_r)) + delta_r;
  always_comb begin
    priority if (esum[pebt_pkg::DELTA_W-1]) begin
      energy_new = '0;
    end else if (esum > $signed(pebt_pkg::DELTA_W'(bmax_r))) begin
      energy_new = bmax_r;
    end else begin
      energy_new = esum[pebt_pkg::BUF_W-1:0];
    end
  end

  // One restoring division step: one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[pebt_pkg::DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign div_ge  = (rem_sh >= {1'b0, den_r});
  assign div_busy = (cnt_r != '0);

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    bmax_nxt      = bmax_r;
    tick_nxt      = tick_r;
    bsum_nxt      = bsum_r;
    scnt_nxt      = scnt_r;
    total_nxt     = total_r;
    nblk_nxt      = nblk_r;
    last_cur_nxt  = last_cur_r;
    energy_nxt    = energy_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    volt_nxt      = volt_r;
    cur_nxt       = cur_r;
    pw_nxt        = pw_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    delta_nxt     = delta_r;
    out_data_nxt  = out_data_r;

    // The result register empties on its transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes; unknown indexes are ignored
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pebt_pkg::REG_POWER_LIMIT: lim_nxt  = cfg_data[pebt_pkg::LIMIT_W-1:0];
        pebt_pkg::REG_BUFFER_MAX:  bmax_nxt = cfg_data;
        pebt_pkg::REG_TICK_MS:     tick_nxt = cfg_data[pebt_pkg::TICK_W-1:0];
        default: ;
      endcase
    end

    // Shared divider step in any division state
    if (div_busy) begin
      rem_nxt = div_ge ? rem_sub[pebt_pkg::DIV_DEN_W-1:0] : rem_sh[pebt_pkg::DIV_DEN_W-1:0];
      quo_nxt = {quo_r[pebt_pkg::DIV_NUM_W-2:0], div_ge};
      cnt_nxt = cnt_r - pebt_pkg::DIV_CNT_W'(1);
    end

    unique case (state_r)
      pebt_pkg::ST_IDLE: begin
        if (in_xfer && !in_tuser) begin
          // A sample closes its block on the last count
          if (scnt_r == pebt_pkg::SAMPLE_CNT_W'(pebt_pkg::BLOCK_SAMPLES - 1)) begin
            if (nblk_r < pebt_pkg::BLOCK_CNT_W'(pebt_pkg::MAX_BLOCKS)) begin
              total_nxt = total_add;
              nblk_nxt  = nblk_r + pebt_pkg::BLOCK_CNT_W'(1);
            end
            bsum_nxt = '0;
            scnt_nxt = '0;
          end else begin
            bsum_nxt = sum_add;
            scnt_nxt = scnt_r + pebt_pkg::SAMPLE_CNT_W'(1);
          end
        end else if (in_xfer) begin
          // A tick starts with the voltage division
          quo_nxt   = pebt_pkg::DIV_NUM_W'(vnum) << (pebt_pkg::DIV_NUM_W - pebt_pkg::VOLT_STEPS);
          rem_nxt   = '0;
          den_nxt   = pebt_pkg::DIV_DEN_W'(pebt_pkg::VOLT_DEN);
          cnt_nxt   = pebt_pkg::DIV_CNT_W'(pebt_pkg::VOLT_STEPS);
          state_nxt = pebt_pkg::ST_VDIV;
        end
      end

      pebt_pkg::ST_VDIV: begin
        if (!div_busy) begin
          volt_nxt = quo_r[pebt_pkg::VOLT_W-1:0];
          if (nblk_r == '0) begin
            cur_nxt   = last_cur_r;
            state_nxt = pebt_pkg::ST_PMUL;
          end else begin
            state_nxt = pebt_pkg::ST_CPREP;
          end
        end
      end

      pebt_pkg::ST_CPREP: begin
        neg_nxt   = diff[pebt_pkg::DIFF_W-1];
        mag_nxt   = diff_abs[pebt_pkg::MAG_W-1:0];
        den_nxt   = pebt_pkg::DIV_DEN_W'(nblk_r) * pebt_pkg::DIV_DEN_W'(pebt_pkg::CUR_DEN_K);
        state_nxt = pebt_pkg::ST_CLOAD;
      end

      pebt_pkg::ST_CLOAD: begin
        quo_nxt   = cnum;
        rem_nxt   = '0;
        cnt_nxt   = pebt_pkg::DIV_CNT_W'(pebt_pkg::CUR_STEPS);
        state_nxt = pebt_pkg::ST_CDIV;
      end

      pebt_pkg::ST_CDIV: begin
        if (!div_busy) begin
          cur_nxt      = neg_r ? -$signed(qcur) : $signed(qcur);
          last_cur_nxt = neg_r ? -$signed(qcur) : $signed(qcur);
          state_nxt    = pebt_pkg::ST_PMUL;
        end
      end

      pebt_pkg::ST_PMUL: begin
        // Totals restart for the next tick period
        total_nxt = '0;
        nblk_nxt  = '0;
        neg_nxt   = cur_r[pebt_pkg::CUR_W-1];
        quo_nxt   = pebt_pkg::DIV_NUM_W'(pnum) << (pebt_pkg::DIV_NUM_W - pebt_pkg::PWR_STEPS);
        rem_nxt   = '0;
        den_nxt   = pebt_pkg::DIV_DEN_W'(pebt_pkg::PWR_DEN);
        cnt_nxt   = pebt_pkg::DIV_CNT_W'(pebt_pkg::PWR_STEPS);
        state_nxt = pebt_pkg::ST_PDIV;
      end

      pebt_pkg::ST_PDIV: begin
        if (!div_busy) begin
          pw_nxt    = neg_r ? -$signed(qpwr) : $signed(qpwr);
          state_nxt = pebt_pkg::ST_ENERGY;
        end
      end

      pebt_pkg::ST_ENERGY: begin
        delta_nxt = $signed(pebt_pkg::DELTA_W'(head))
                  * $signed(pebt_pkg::DELTA_W'(tick_r));
        state_nxt = pebt_pkg::ST_EOUT;
      end

      pebt_pkg::ST_EOUT: begin
        // The buffer moves only when the result can be loaded
        if (!out_valid_r || out_tready) begin
          energy_nxt    = energy_new;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, energy_new, pw_r, volt_r, cur_r};
          state_nxt     = pebt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pebt_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pebt_pkg::ST_IDLE;
      lim_r       <= pebt_pkg::RST_POWER_LIMIT;
      bmax_r      <= pebt_pkg::RST_BUFFER_MAX;
      tick_r      <= pebt_pkg::RST_TICK_MS;
      bsum_r      <= '0;
      scnt_r      <= '0;
      total_r     <= '0;
      nblk_r      <= '0;
      last_cur_r  <= '0;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      lim_r       <= lim_nxt;
      bmax_r      <= bmax_nxt;
      tick_r      <= tick_nxt;
      bsum_r      <= bsum_nxt;
      scnt_r      <= scnt_nxt;
      total_r     <= total_nxt;
      nblk_r      <= nblk_nxt;
      last_cur_r  <= last_cur_nxt;
      energy_r    <= energy_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    volt_r     <= volt_nxt;
    cur_r      <= cur_nxt;
    pw_r       <= pw_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    delta_r    <= delta_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/pebt_checker.sv
`timescale 1ns / 1ps

module pebt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pebt_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The current field stays within its clamp
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) <= 15'sd8500) &&
                   ($signed(out_tdata[14:0]) >= -15'sd8500))
    else $error("current out of range");

  // The power field stays within its clamp
  a_pwr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[54:33]) <= 22'sd1560000) &&
                   ($signed(out_tdata[54:33]) >= -22'sd1560000))
    else $error("power out of range");

  // A sample transfer never produces a result
  a_sample_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result appeared after a sample");

  // A tick occupies the block, so input is held off next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input accepted during tick processing");

endmodule

bind power_energy_buffer_tracker pebt_checker u_pebt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
